// File: rtl/gdad_pkg.sv
// gdad_pkg: types, constants, tables and sequencer states for the date adder
// no dependencies; imported by the interfaces and every module

package gdad_pkg;

    typedef logic [4:0]  day_t;
    typedef logic [3:0]  month_t;
    typedef logic [13:0] year_t;
    typedef logic [15:0] nights_t;
    typedef logic [2:0]  wday_t;
    typedef logic [15:0] opw_t;    // shared compare/subtract operand
    typedef logic [6:0]  cent_t;   // year / 100 and year % 100
    typedef logic [9:0]  zsum_t;   // zeller sum before mod 7

    localparam month_t      MONTHS_PER_YEAR = 4'd12;
    localparam month_t      MONTH_FEB       = 4'd2;
    localparam month_t      MONTH_MAR       = 4'd3;
    localparam year_t       YEAR_LAST       = 14'd9999;
    localparam cent_t       CENT_LAST       = 7'd99;
    localparam year_t       CENTURY         = 14'd100;
    localparam zsum_t       DAYS_PER_WEEK   = 10'd7;
    // reciprocals: year * 5243 >> 19 is year / 100 up to 43689,
    // sum * 1171 >> 13 is sum / 7 up to 1638
    localparam logic [12:0] DIV100_MUL      = 13'd5243;
    localparam logic [10:0] MOD7_MUL        = 11'd1171;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_WALK,
        ST_ZSUM,
        ST_MOD,
        ST_DONE
    } state_t;

    // month length, month is 1..12
    function automatic day_t month_days(input month_t m, input logic leap);
        day_t d;
        case (m)
            4'd1:    d = 5'd31;
            4'd2:    d = leap ? 5'd29 : 5'd28;
            4'd3:    d = 5'd31;
            4'd4:    d = 5'd30;
            4'd5:    d = 5'd31;
            4'd6:    d = 5'd30;
            4'd7:    d = 5'd31;
            4'd8:    d = 5'd31;
            4'd9:    d = 5'd30;
            4'd10:   d = 5'd31;
            4'd11:   d = 5'd30;
            4'd12:   d = 5'd31;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

    // floor(13 * (m' + 1) / 5), with january and february as months 13 and 14
    function automatic logic [5:0] zeller_month_term(input month_t m);
        logic [5:0] t;
        case (m)
            4'd1:    t = 6'd36;
            4'd2:    t = 6'd39;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

// File: rtl/gdad_if.sv
// gdad_in_if and gdad_out_if: valid/ready channels carrying the date payloads
// depends on gdad_pkg for the field types

interface gdad_in_if import gdad_pkg::*; ();
    logic    valid;
    logic    ready;
    day_t    start_day;
    month_t  start_month;
    year_t   start_year;
    nights_t nights;

    modport source (output valid, start_day, start_month, start_year, nights, input ready);
    modport sink   (input valid, start_day, start_month, start_year, nights, output ready);
endinterface

interface gdad_out_if import gdad_pkg::*; ();
    logic   valid;
    logic   ready;
    day_t   end_day;
    month_t end_month;
    year_t  end_year;
    wday_t  weekday;
    logic   bad_input;

    modport source (output valid, end_day, end_month, end_year, weekday, bad_input,
                    input ready);
    modport sink   (input valid, end_day, end_month, end_year, weekday, bad_input,
                    output ready);
endinterface

// File: rtl/gdad_cmp_sub.sv
// gdad_cmp_sub: the shared compare and subtract unit of the date adder
// depends on gdad_pkg

module gdad_cmp_sub import gdad_pkg::*;
(
    input  opw_t a,
    input  opw_t b,
    output logic ge,
    output opw_t diff
);

    logic [16:0] wide;

    // borrow out of a - b tells whether a >= b
    assign wide = {1'b0, a} - {1'b0, b};
    assign ge   = ~wide[16];
    assign diff = wide[15:0];

endmodule

// File: rtl/gdad_month_len.sv
// gdad_month_len: month length with the gregorian leap-year rule
// depends on gdad_pkg; year is given as quotient and remainder by 100

module gdad_month_len import gdad_pkg::*;
(
    input  month_t month,
    input  cent_t  year_rem,
    input  cent_t  year_quo,
    output day_t   days
);

    logic leap;

    // century years are leap only when the century count is a multiple of 4
    assign leap = (year_rem != 7'd0) ? (year_rem[1:0] == 2'b00) : (year_quo[1:0] == 2'b00);
    assign days = month_days(month, leap);

endmodule

// File: rtl/gregorian_date_add_days.sv
// gregorian_date_add_days: top level, sequencer and datapath of the date adder
// depends on gdad_pkg, gdad_if, gdad_cmp_sub and gdad_month_len

// usage
//   date_in carries a starting date (day, month, year) and a night count; a
//   transfer happens when valid and ready are both high. ready is high only
//   while the sequencer is idle, so one date is worked on at a time.
//   date_out carries the resulting date, its weekday (0 saturday .. 6 friday)
//   and bad_input. an invalid start date comes back unchanged with weekday 0.
// sequence
//   after the input transfer the sequencer splits the year by 100, checks the
//   day, walks month by month until the nights fit and then finishes the walk,
//   forms the zeller sum, takes it mod 7 and loads the output register. a field
//   out of range goes straight to the output load, and a day past its month end
//   goes there after the split and the check. ready comes back the cycle after
//   the output load, so a new date is taken only once the last one is finished;
//   the length of the month walk through the shared compare/subtract unit sets
//   how long a date takes.
// reset and stall
//   rst_n clears the sequencer and the output valid flag at once. a finished
//   result sits in the output register; while it waits the next date is
//   accepted and worked on, and only its final load waits for the transfer.

module gregorian_date_add_days import gdad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    gdad_in_if.sink     date_in,
    gdad_out_if.source  date_out
);

    state_t  state_reg, state_next;

    // working registers
    day_t    day_reg, day_next;
    month_t  month_reg, month_next;
    year_t   year_reg, year_next;
    nights_t nights_reg, nights_next;
    year_t   rem_reg, rem_next;      // year, then year % 100, zeller sum, weekday
    cent_t   quo_reg, quo_next;      // year / 100
    logic    bad_reg, bad_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    day_t    out_day_reg, out_day_next;
    month_t  out_month_reg, out_month_next;
    year_t   out_year_reg, out_year_next;
    wday_t   out_wday_reg, out_wday_next;
    logic    out_bad_reg, out_bad_next;

    // shared unit
    opw_t    op_a, op_b, op_diff;
    logic    op_ge;

    day_t    dim;
    day_t    rest;
    logic    range_bad;
    logic    out_free;
    cent_t   zk, zj;
    zsum_t   zsum;

    // constant division by reciprocal multiplication
    logic [25:0] div_prod;
    cent_t       div_quo;
    year_t       div_rem;
    logic [19:0] mod_prod;
    logic [6:0]  mod_quo;
    zsum_t       mod_rem;

    gdad_cmp_sub u_cmp_sub
    (
        .a    (op_a),
        .b    (op_b),
        .ge   (op_ge),
        .diff (op_diff)
    );

    // in check the remainder and quotient are fresh from the division
    gdad_month_len u_month_len
    (
        .month    (month_reg),
        .year_rem (rem_reg[6:0]),
        .year_quo (quo_reg),
        .days     (dim)
    );

    assign rest      = dim - day_reg;
    assign out_free  = ~out_valid_reg | date_out.ready;
    assign range_bad = (date_in.start_month == 4'd0) ||
                       (date_in.start_month > MONTHS_PER_YEAR) ||
                       (date_in.start_year == 14'd0) ||
                       (date_in.start_year > YEAR_LAST) ||
                       (date_in.start_day == 5'd0);

    // year split by 100 while rem_reg holds the year
    assign div_prod = {12'd0, rem_reg} * {13'd0, DIV100_MUL};
    assign div_quo  = div_prod[25:19];
    assign div_rem  = rem_reg - {7'd0, div_quo} * CENTURY;

    // zeller sum mod 7 while rem_reg holds the sum
    assign mod_prod = {10'd0, rem_reg[9:0]} * {9'd0, MOD7_MUL};
    assign mod_quo  = mod_prod[19:13];
    assign mod_rem  = rem_reg[9:0] - {3'd0, mod_quo} * DAYS_PER_WEEK;

    // operand select for the shared unit
    always_comb
    begin
        case (state_reg)
            ST_WALK:
            begin
                // ge means more nights than the days left in this month
                op_a = nights_reg;
                op_b = {11'd0, rest} + 16'd1;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // zeller year terms; january and february count in the previous year
    always_comb
    begin
        if (month_reg < MONTH_MAR)
        begin
            zk = (rem_reg[6:0] == 7'd0) ? CENT_LAST : rem_reg[6:0] - 7'd1;
            zj = (rem_reg[6:0] == 7'd0) ? quo_reg - 7'd1 : quo_reg;
        end
        else
        begin
            zk = rem_reg[6:0];
            zj = quo_reg;
        end
        zsum = zsum_t'(day_reg) + zsum_t'(zeller_month_term(month_reg))
             + zsum_t'(zk) + zsum_t'(zk >> 2) + zsum_t'(zj >> 2)
             + (zsum_t'(zj) << 2) + zsum_t'(zj);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (date_in.valid)
                begin
                    state_next = range_bad ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = (day_reg > dim) ? ST_DONE : ST_WALK;
            end
            ST_WALK:
            begin
                if (!op_ge)
                begin
                    state_next = ST_ZSUM;
                end
            end
            ST_ZSUM:
            begin
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        nights_next    = nights_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg & ~date_out.ready;
        out_day_next   = out_day_reg;
        out_month_next = out_month_reg;
        out_year_next  = out_year_reg;
        out_wday_next  = out_wday_reg;
        out_bad_next   = out_bad_reg;
        case (state_reg)
            ST_IDLE:
            begin
                day_next    = date_in.start_day;
                month_next  = date_in.start_month;
                year_next   = date_in.start_year;
                nights_next = date_in.nights;
                rem_next    = date_in.start_year;
                quo_next    = '0;
                bad_next    = range_bad;
            end
            ST_DIV:
            begin
                rem_next = div_rem;
                quo_next = div_quo;
            end
            ST_CHECK:
            begin
                bad_next = (day_reg > dim);
            end
            ST_WALK:
            begin
                if (op_ge)
                begin
                    // skip to the first of next month
                    nights_next = op_diff;
                    day_next    = 5'd1;
                    if (month_reg == MONTHS_PER_YEAR)
                    begin
                        month_next = 4'd1;
                        year_next  = year_reg + 14'd1;
                        if (rem_reg[6:0] == CENT_LAST)
                        begin
                            rem_next = '0;
                            quo_next = quo_reg + 7'd1;
                        end
                        else
                        begin
                            rem_next = rem_reg + 14'd1;
                        end
                    end
                    else
                    begin
                        month_next = month_reg + 4'd1;
                    end
                end
                else
                begin
                    // remaining nights fit in this month
                    day_next    = day_reg + nights_reg[4:0];
                    nights_next = '0;
                end
            end
            ST_ZSUM:
            begin
                rem_next = year_t'(zsum);
            end
            ST_MOD:
            begin
                rem_next = year_t'(mod_rem);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_day_next   = day_reg;
                    out_month_next = month_reg;
                    out_year_next  = year_reg;
                    out_wday_next  = bad_reg ? 3'd0 : rem_reg[2:0];
                    out_bad_next   = bad_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        day_reg       <= day_next;
        month_reg     <= month_next;
        year_reg      <= year_next;
        nights_reg    <= nights_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        bad_reg       <= bad_next;
        out_day_reg   <= out_day_next;
        out_month_reg <= out_month_next;
        out_year_reg  <= out_year_next;
        out_wday_reg  <= out_wday_next;
        out_bad_reg   <= out_bad_next;
    end

    assign date_in.ready      = (state_reg == ST_IDLE);
    assign date_out.valid     = out_valid_reg;
    assign date_out.end_day   = out_day_reg;
    assign date_out.end_month = out_month_reg;
    assign date_out.end_year  = out_year_reg;
    assign date_out.weekday   = out_wday_reg;
    assign date_out.bad_input = out_bad_reg;

endmodule
